### sv/lfu_pkg.sv
// shared types and constants for the lfu cache table
package lfu_pkg;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } res_t;
endpackage

### sv/lfu_if.sv
// valid/ready channel interfaces for operations and results
interface lfu_op_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  op_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfu_res_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/lfu_front.sv
// front end: accepts operations into a short queue
module lfu_front import lfu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  lfu_op_if.sink in,
  output logic   q_valid,
  output op_t    q_data,
  input  logic   q_pop
);
  localparam int unsigned PW = $clog2(QDEPTH);
  op_t q_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in.ready = (cnt_r != (PW+1)'(QDEPTH));
  assign push = in.valid && in.ready;
  assign pop = q_pop && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_data = q_r[rp_r];

  always_comb begin
    wp_nxt = push ? ((wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? ((rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= in.data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !q_valid) else $error("pop from empty queue");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PW+1)'(QDEPTH)) |-> !in.ready) else $error("push when full");
endmodule

### sv/lfu_back.sv
// back end: lookup, victim search and table update
module lfu_back import lfu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] cap,
  input  logic             q_valid,
  input  op_t              q_data,
  output logic             q_pop,
  lfu_res_if.source        out
);
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned OW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_VICT = 3'd2,
                         S_DO = 3'd3, S_OUT = 3'd4;

  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [KEY_W-1:0]      key_r [TABLE_ENTRIES];
  logic [VAL_W-1:0]      val_r [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_r [TABLE_ENTRIES];
  logic [STAMP_W-1:0]    stp_r [TABLE_ENTRIES];
  logic [STAMP_W-1:0]    stamp_r;
  logic [OW-1:0]         occ_r;
  logic [2:0]            st_r;
  op_t                   op_r;
  logic [TABLE_ENTRIES-1:0] match_r;
  logic [IW-1:0]         idx_r, best_r, free_r;
  logic                  best_ok_r, free_ok_r;
  logic [COUNT_BITS-1:0] bcnt_r;
  logic [STAMP_W-1:0]    bage_r;
  res_t                  res_r;
  logic                  ovld_r;

  logic hit;
  logic [IW-1:0] hidx;
  logic [IW-1:0] fidx;
  logic [STAMP_W-1:0] age;
  logic [OW-1:0] capc;
  logic better;
  logic evict;

  always_comb begin
    hit = |match_r;
    hidx = '0;
    fidx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hidx = IW'(i);
      if (!vld_r[i]) fidx = IW'(i);
    end
  end
  assign capc = (32'(cap) > 32'(TABLE_ENTRIES)) ? OW'(TABLE_ENTRIES) : OW'(cap);
  assign age = stamp_r - stp_r[idx_r];
  assign better = !best_ok_r || cnt_r[idx_r] < bcnt_r ||
                  (cnt_r[idx_r] == bcnt_r && age > bage_r);
  assign evict = (op_r.kind == KIND_PUT) && (capc != '0) && !hit && best_ok_r;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out.valid = ovld_r;
  assign out.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vld_r <= '0;
      stamp_r <= '0;
      occ_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (out.valid && out.ready) ovld_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          op_r <= q_data;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            match_r[i] <= vld_r[i] && key_r[i] == q_data.key;
          st_r <= S_SCAN;
        end
        S_SCAN: begin
          // pick free slot; start victim scan if a put misses and the table is at capacity
          free_ok_r <= ~&vld_r;
          free_r <= fidx;
          idx_r <= '0;
          best_ok_r <= 1'b0;
          if (op_r.kind == KIND_PUT && capc != '0 && !hit && occ_r >= capc)
            st_r <= S_VICT;
          else
            st_r <= S_DO;
        end
        S_VICT: begin
          // one entry per cycle; equal counts go to the older entry, then the lower index
          if (vld_r[idx_r] && better) begin
            best_ok_r <= 1'b1;
            best_r <= idx_r;
            bcnt_r <= cnt_r[idx_r];
            bage_r <= age;
          end
          if (idx_r == IW'(TABLE_ENTRIES - 1)) st_r <= S_DO;
          else idx_r <= idx_r + 1'b1;
        end
        S_DO: if (!ovld_r) begin
          res_r.found <= hit;
          res_r.read_value <= (op_r.kind == KIND_GET) ? (hit ? val_r[hidx] : '1) : '0;
          res_r.evicted <= evict;
          res_r.evicted_key <= evict ? key_r[best_r] : '0;
          if (op_r.kind == KIND_GET) begin
            if (hit) begin
              if (cnt_r[hidx] != CMAX) cnt_r[hidx] <= cnt_r[hidx] + 1'b1;
              stp_r[hidx] <= stamp_r;
              stamp_r <= stamp_r + 1'b1;
            end
          end else if (capc != '0) begin
            if (hit) begin
              if (cnt_r[hidx] != CMAX) cnt_r[hidx] <= cnt_r[hidx] + 1'b1;
              stp_r[hidx] <= stamp_r;
              val_r[hidx] <= op_r.value;
              stamp_r <= stamp_r + 1'b1;
            end else if (best_ok_r) begin
              // evicted slot is reused by the new key
              key_r[best_r] <= op_r.key;
              val_r[best_r] <= op_r.value;
              cnt_r[best_r] <= COUNT_BITS'(1);
              stp_r[best_r] <= stamp_r;
              stamp_r <= stamp_r + 1'b1;
            end else if (free_ok_r) begin
              vld_r[free_r] <= 1'b1;
              key_r[free_r] <= op_r.key;
              val_r[free_r] <= op_r.value;
              cnt_r[free_r] <= COUNT_BITS'(1);
              stp_r[free_r] <= stamp_r;
              stamp_r <= stamp_r + 1'b1;
              occ_r <= occ_r + 1'b1;
            end
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          ovld_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OW'($countones(vld_r))) else $error("occupancy mismatch");
  a_ev_put: assert property (@(posedge clk) disable iff (!rst_n)
    (out.valid && out.data.evicted) |-> !out.data.found) else $error("evict on hit");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out.valid && !out.ready) |=> out.valid && $stable(out.data)) else $error("result lost");
endmodule

### sv/lfu_cache_table.sv
// top level of the lfu cache table
// channel | dir | payload
// in      | in  | kind, key, value
// out     | out | found, read_value, evicted, evicted_key
// cfg     | in  | capacity_in_use (write only)
// an item passes lookup, slot pick, update and result steps when no eviction
// is needed; an eviction adds a serial victim scan over all TABLE_ENTRIES entries.
// reset is synchronous and clears valid bits, occupancy and stamp counter.
// the back end holds in its update step while a result waits on out_ready.
// a two-entry queue takes further input while a result waits on out_ready, until it is full.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lfu_op_if.sink           in_ch,
  lfu_res_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);
  logic [CAP_W-1:0] cap_r;
  logic q_valid, q_pop;
  op_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lfu_front u_front (.clk, .rst_n, .in(in_ch), .q_valid, .q_data, .q_pop);
  lfu_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .cap(cap_r), .q_valid, .q_data, .q_pop, .out(out_ch));
endmodule
